>>> design/dwc_pkg.sv
// Package for the duplicate word counter: sizes, command codes, state type and result struct.
// No dependencies; used by the input channel interface, the top level and the testbench.
package dwc_pkg;
  localparam int MAX_ENTRIES  = 64;
  localparam int MAX_WORD_LEN = 49;
  localparam int COUNT_BITS   = 16;

  localparam int LEN_W   = 6;                        // entry_length field width
  localparam int IDX_W   = $clog2(MAX_ENTRIES);
  localparam int TOT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W   = $clog2(MAX_WORD_LEN + 1);
  localparam int WORDS   = MAX_ENTRIES * MAX_WORD_LEN;
  localparam int ADDR_W  = $clog2(WORDS + 64);       // room for query offsets
  localparam int OCNT_W  = 16;                       // entry_count field width

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_END   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_LEN_RD   = 12'b000000000010,
    S_LEN_CHK  = 12'b000000000100,
    S_BYTE_RD  = 12'b000000001000,
    S_BYTE_CHK = 12'b000000010000,
    S_CNT_RD   = 12'b000000100000,
    S_CNT_UPD  = 12'b000001000000,
    S_COPY_RD  = 12'b000010000000,
    S_COPY_WR  = 12'b000100000000,
    S_QRY      = 12'b001000000000,
    S_OUT      = 12'b010000000000,
    S_QRY_RD   = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0]  entry_index;
    logic [OCNT_W-1:0] entry_count;
    logic              is_new;
    logic              table_full;
    logic              word_too_long;
    logic [7:0]        entry_byte;
    logic [LEN_W-1:0]  entry_length;
  } res_t;
endpackage

>>> design/dwc_in_if.sv
// Input channel of the duplicate word counter: valid/ready plus command fields.
// Depends on dwc_pkg.
interface dwc_in_if;
  import dwc_pkg::*;
  logic       valid;
  logic       ready;
  cmd_t       command;
  logic [7:0] char_byte;
  logic [5:0] query_index;
  logic [5:0] char_position;
  modport source(output valid, command, char_byte, query_index, char_position,
                 input ready);
  modport sink(input valid, command, char_byte, query_index, char_position,
               output ready);
endinterface

>>> design/dwc_out_if.sv
// Result channel of the duplicate word counter: valid/ready plus result fields.
// No package needed; widths follow the result format.
interface dwc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  entry_index;
  logic [15:0] entry_count;
  logic        is_new;
  logic        table_full;
  logic        word_too_long;
  logic [7:0]  entry_byte;
  logic [5:0]  entry_length;
  logic [6:0]  distinct_entries;
  logic        any_duplicate;
  modport source(output valid, entry_index, entry_count, is_new, table_full,
                 word_too_long, entry_byte, entry_length, distinct_entries,
                 any_duplicate, input ready);
  modport sink(input valid, entry_index, entry_count, is_new, table_full,
               word_too_long, entry_byte, entry_length, distinct_entries,
               any_duplicate, output ready);
endinterface

>>> design/duplicate_word_counter_unit.sv
// Duplicate word counter top level: word buffer, entry table memories, sequencer.
// Depends on dwc_pkg, dwc_in_if and dwc_out_if.
//
// Counts words streamed a byte per beat. A push or a clear goes from idle to
// the output state; a query of a stored entry first passes S_QRY_RD and S_QRY.
// End word walks the stored entries one at a time through a single compare
// unit fed by the registered read ports of the length, word and buffer
// memories: a read and a check state per entry for the length check and per
// byte compared when lengths agree, then a count read and update, or a read
// and a write per byte for an insert copy. The block takes one beat at a time
// (ready only while idle); a finished result sits in the output register and
// the next beat is accepted while it waits. No clearing pass after reset:
// entries beyond the stored total are never read.
module duplicate_word_counter_unit (
  input logic      clk,
  input logic      rst_n,
  dwc_in_if.sink   in_chan,
  dwc_out_if.source out_chan
);
  import dwc_pkg::*;

  // storage
  logic [7:0]        wbuf_mem  [MAX_WORD_LEN];
  logic [7:0]        words_mem [WORDS];
  logic [LEN_W-1:0]  lens_mem  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] cnts_mem [MAX_ENTRIES];

  state_t state_r, state_nxt;
  logic [POS_W-1:0]  wlen_r, wlen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              dup_r, dup_nxt;
  logic [IDX_W-1:0]  ent_r, ent_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  res_t              res_r, res_nxt;

  // registered read data
  logic [7:0]            bbyte_q, wbyte_q;
  logic [LEN_W-1:0]      len_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [ADDR_W-1:0]     waddr;

  // write strobes
  logic              wbuf_we;
  logic              words_we;
  logic              ent_we;
  logic              cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_inc;

  logic              out_valid_r;
  res_t              out_r;
  logic              out_free;
  logic              in_fire;
  logic [TOT_W-1:0]  ent_next_cnt;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign waddr         = base_r + ADDR_W'(pos_r);
  assign ent_next_cnt  = TOT_W'(ent_r) + TOT_W'(1);
  assign cnt_inc       = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);

  // memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (wbuf_we) begin
      wbuf_mem[wlen_r] <= in_chan.char_byte;
    end
    bbyte_q <= wbuf_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (words_we) begin
      words_mem[waddr] <= bbyte_q;
    end
    wbyte_q <= words_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      lens_mem[ent_r] <= LEN_W'(wlen_r);
    end
    len_q <= lens_mem[ent_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnts_mem[ent_r] <= cnt_wdata;
    end
    cnt_q <= cnts_mem[ent_r];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    wlen_nxt  = wlen_r;
    ovf_nxt   = ovf_r;
    total_nxt = total_r;
    dup_nxt   = dup_r;
    ent_nxt   = ent_r;
    base_nxt  = base_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    wbuf_we   = 1'b0;
    words_we  = 1'b0;
    ent_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_inc;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          state_nxt = S_OUT;
          case (in_chan.command)
            CMD_PUSH: begin
              if (wlen_r < POS_W'(MAX_WORD_LEN)) begin
                wbuf_we  = 1'b1;
                wlen_nxt = wlen_r + POS_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              res_nxt.entry_length  = LEN_W'(wlen_nxt);
              res_nxt.word_too_long = ovf_nxt;
            end
            CMD_END: begin
              ent_nxt  = '0;
              base_nxt = '0;
              pos_nxt  = '0;
              if (wlen_r == '0) begin
                ovf_nxt = 1'b0;          // empty word: table untouched
              end else if (total_r == '0) begin
                state_nxt = S_COPY_RD;
              end else begin
                state_nxt = S_LEN_RD;
              end
            end
            CMD_QUERY: begin
              ent_nxt = in_chan.query_index;
              res_nxt.entry_index = in_chan.query_index;
              if (TOT_W'(in_chan.query_index) < total_r) begin
                base_nxt  = ADDR_W'(in_chan.query_index) * ADDR_W'(MAX_WORD_LEN);
                pos_nxt   = POS_W'(in_chan.char_position);
                state_nxt = S_QRY_RD;
              end
            end
            CMD_CLEAR: begin
              total_nxt = '0;
              dup_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      S_LEN_RD: state_nxt = S_LEN_CHK;

      S_LEN_CHK, S_BYTE_CHK: begin
        if ((state_r == S_LEN_CHK) && (POS_W'(len_q) == wlen_r)) begin
          pos_nxt   = '0;
          state_nxt = S_BYTE_RD;
        end else if ((state_r == S_BYTE_CHK) && (wbyte_q == bbyte_q)) begin
          if (pos_r + POS_W'(1) == wlen_r) begin
            state_nxt = S_CNT_RD;
          end else begin
            pos_nxt   = pos_r + POS_W'(1);
            state_nxt = S_BYTE_RD;
          end
        end else begin
          // no match here: step to the next entry or fall out of the table
          base_nxt = base_r + ADDR_W'(MAX_WORD_LEN);
          pos_nxt  = '0;
          if (ent_next_cnt == total_r) begin
            if (total_r == TOT_W'(MAX_ENTRIES)) begin
              res_nxt.table_full    = 1'b1;
              res_nxt.word_too_long = ovf_r;
              wlen_nxt  = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_OUT;
            end else begin
              ent_nxt   = IDX_W'(total_r);
              state_nxt = S_COPY_RD;
            end
          end else begin
            ent_nxt   = ent_r + IDX_W'(1);
            state_nxt = S_LEN_RD;
          end
        end
      end

      S_BYTE_RD: state_nxt = S_BYTE_CHK;

      S_CNT_RD: state_nxt = S_CNT_UPD;

      S_CNT_UPD: begin
        cnt_we = 1'b1;
        if (cnt_inc > COUNT_BITS'(1)) begin
          dup_nxt = 1'b1;
        end
        res_nxt.entry_index   = ent_r;
        res_nxt.entry_count   = OCNT_W'(cnt_inc);
        res_nxt.entry_length  = len_q;
        res_nxt.word_too_long = ovf_r;
        wlen_nxt  = '0;
        ovf_nxt   = 1'b0;
        state_nxt = S_OUT;
      end

      S_COPY_RD: state_nxt = S_COPY_WR;

      S_COPY_WR: begin
        words_we = 1'b1;
        if (pos_r + POS_W'(1) == wlen_r) begin
          ent_we    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = COUNT_BITS'(1);
          total_nxt = total_r + TOT_W'(1);
          res_nxt.entry_index   = ent_r;
          res_nxt.entry_count   = OCNT_W'(1);
          res_nxt.is_new        = 1'b1;
          res_nxt.entry_length  = LEN_W'(wlen_r);
          res_nxt.word_too_long = ovf_r;
          wlen_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_OUT;
        end else begin
          pos_nxt   = pos_r + POS_W'(1);
          state_nxt = S_COPY_RD;
        end
      end

      // query reads of ent_r and waddr are in flight
      S_QRY_RD: state_nxt = S_QRY;

      S_QRY: begin
        // read data has landed; byte reads as zero past the word's end
        res_nxt.entry_count  = OCNT_W'(cnt_q);
        res_nxt.entry_length = len_q;
        if (pos_r < POS_W'(len_q)) begin
          res_nxt.entry_byte = wbyte_q;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wlen_r  <= '0;
      ovf_r   <= 1'b0;
      total_r <= '0;
      dup_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wlen_r  <= wlen_nxt;
      ovf_r   <= ovf_nxt;
      total_r <= total_nxt;
      dup_r   <= dup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    base_r <= base_nxt;
    pos_r  <= pos_nxt;
    res_r  <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_r <= res_r;
    end
  end

  logic [TOT_W-1:0] out_total_r;
  logic             out_dup_r;
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_total_r <= total_r;
      out_dup_r   <= dup_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.entry_index      = out_r.entry_index;
  assign out_chan.entry_count      = out_r.entry_count;
  assign out_chan.is_new           = out_r.is_new;
  assign out_chan.table_full       = out_r.table_full;
  assign out_chan.word_too_long    = out_r.word_too_long;
  assign out_chan.entry_byte       = out_r.entry_byte;
  assign out_chan.entry_length     = out_r.entry_length;
  assign out_chan.distinct_entries = out_total_r;
  assign out_chan.any_duplicate    = out_dup_r;

  // checks
  a_wlen_max: assert property (@(posedge clk) disable iff (!rst_n)
    wlen_r <= POS_W'(MAX_WORD_LEN))
    else $error("word length past buffer depth");

  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(MAX_ENTRIES))
    else $error("entry total past table depth");

  a_new_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_new |->
      TOT_W'(out_r.entry_index) + TOT_W'(1) == out_total_r)
    else $error("inserted entry is not the last one");

  a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.table_full |-> out_total_r == TOT_W'(MAX_ENTRIES))
    else $error("table full flagged below capacity");
endmodule

>>> test/duplicate_word_counter_unit_tb.sv
// Self-checking testbench for duplicate_word_counter_unit: word pushes, end-word lookups,
// queries and clears, checked beat by beat against an in-bench table predictor.
// Depends on dwc_pkg, dwc_in_if, dwc_out_if and the block's top level.
module duplicate_word_counter_unit_tb;
  import dwc_pkg::*;

  localparam int ITEMS_PER_PHASE = 215;
  localparam int HOLD_CYCLES     = 600;
  localparam int CYCLE_LIMIT     = 30000000;
  localparam int DRAIN_CYCLES    = 7000;   // one worst-case end-word walk
  localparam int MAX_REPORTS     = 10;

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [5:0]  index;
    logic [15:0] count;
    logic        is_new;
    logic        full;
    logic        too_long;
    logic [7:0]  data;
    logic [5:0]  length;
    logic [6:0]  distinct;
    logic        dup;
  } word_result_t;

  // Scoreboard: mirrors the word table and holds expected result beats.
  class word_table_scoreboard;
    logic [7:0]   stored_words [MAX_ENTRIES][MAX_WORD_LEN];
    int           stored_len   [MAX_ENTRIES];
    logic [15:0]  stored_count [MAX_ENTRIES];
    int           stored_total;
    bit           dup_seen;
    logic [7:0]   pending_word [MAX_WORD_LEN];
    int           pending_len;
    bit           pending_ovf;
    word_result_t pending_results[$];
    int           errors;

    function void clear_state();
      stored_total = 0;
      dup_seen     = 0;
      pending_len  = 0;
      pending_ovf  = 0;
      errors       = 0;
      pending_results.delete();
    endfunction

    // accepted input beat: update table copy and queue the expected result
    function void note_beat(cmd_t cmd, logic [7:0] b, logic [5:0] qi, logic [5:0] qp);
      word_result_t r;
      int           e;
      bit           found;
      r = '0;
      found = 0;
      case (cmd)
        CMD_PUSH: begin
          if (pending_len < MAX_WORD_LEN) begin
            pending_word[pending_len] = b;
            pending_len++;
          end else begin
            pending_ovf = 1;
          end
          r.length   = 6'(pending_len);
          r.too_long = pending_ovf;
        end
        CMD_END: begin
          if (pending_len > 0) begin
            r.too_long = pending_ovf;
            for (e = 0; e < stored_total; e++) begin
              if (stored_len[e] == pending_len) begin
                found = 1;
                for (int k = 0; k < pending_len; k++)
                  if (stored_words[e][k] != pending_word[k]) found = 0;
              end
              if (found) break;
            end
            if (found) begin
              if (stored_count[e] != 16'hFFFF) stored_count[e]++;
              if (stored_count[e] > 1) dup_seen = 1;
              r.index  = 6'(e);
              r.count  = stored_count[e];
              r.length = 6'(stored_len[e]);
            end else if (stored_total < MAX_ENTRIES) begin
              e = stored_total;
              for (int k = 0; k < pending_len; k++) stored_words[e][k] = pending_word[k];
              stored_len[e]   = pending_len;
              stored_count[e] = 16'd1;
              stored_total++;
              r.index  = 6'(e);
              r.count  = 16'd1;
              r.length = 6'(pending_len);
              r.is_new = 1'b1;
            end else begin
              r.full = 1'b1;
            end
          end
          pending_len = 0;
          pending_ovf = 0;
        end
        CMD_QUERY: begin
          r.index = qi;
          if (qi < stored_total) begin
            r.count  = stored_count[qi];
            r.length = 6'(stored_len[qi]);
            if (qp < stored_len[qi]) r.data = stored_words[qi][qp];
          end
        end
        default: begin
          stored_total = 0;
          dup_seen     = 0;
        end
      endcase
      r.distinct = 7'(stored_total);
      r.dup      = dup_seen;
      pending_results.push_back(r);
    endfunction

    function void check_result(word_result_t act);
      word_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR: unexpected result beat %p", act);
        return;
      end
      exp_r = pending_results.pop_front();
      if (act !== exp_r) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result mismatch\n  expected %p\n  actual   %p", exp_r, act);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  dwc_in_if  in_chan();
  dwc_out_if out_chan();

  duplicate_word_counter_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  word_table_scoreboard sb;
  int   idle_pct;       // sender idle odds, percent per cycle
  int   stall_pct;      // receiver stall odds, percent per cycle
  logic holding;        // long receiver hold-off in progress
  event hold_go;
  int   cycles;
  int   sent;

  // word vocabulary for well-formed random words, reused to make repeats
  logic [7:0] vocab_bytes [96][52];
  int         vocab_len   [96];

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  initial begin
    in_chan.valid         = 1'b0;
    in_chan.command       = CMD_PUSH;
    in_chan.char_byte     = '0;
    in_chan.query_index   = '0;
    in_chan.char_position = '0;
    out_chan.ready        = 1'b0;
    holding               = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    cycles                = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL duplicate_word_counter_unit");
      $finish;
    end
  end

  // long hold-off, counted here so the sender keeps offering beats meanwhile
  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  // result side: check on handshake, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_result({out_chan.entry_index, out_chan.entry_count, out_chan.is_new,
                       out_chan.table_full, out_chan.word_too_long, out_chan.entry_byte,
                       out_chan.entry_length, out_chan.distinct_entries,
                       out_chan.any_duplicate});
    out_chan.ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  // offer one beat, idling first at random; returns after it is accepted
  task automatic send_beat(cmd_t cmd, logic [7:0] b, logic [5:0] qi, logic [5:0] qp);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.command       <= cmd;
    in_chan.char_byte     <= b;
    in_chan.query_index   <= qi;
    in_chan.char_position <= qp;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_beat(cmd, b, qi, qp);
    sent++;
  endtask

  task automatic send_vocab_word(int w);
    for (int k = 0; k < vocab_len[w]; k++) send_beat(CMD_PUSH, vocab_bytes[w][k], '0, '0);
    send_beat(CMD_END, 8'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // build a fresh vocabulary: mostly short words, a few near or past the limit
  task automatic fill_vocab();
    for (int w = 0; w < 96; w++) begin
      case ($urandom_range(19))
        0:       vocab_len[w] = $urandom_range(45, 52);
        1, 2:    vocab_len[w] = $urandom_range(5, 20);
        default: vocab_len[w] = $urandom_range(1, 4);
      endcase
      for (int k = 0; k < 52; k++)
        vocab_bytes[w][k] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(97, 100));
    end
  endtask

  task automatic random_phase(int n_items, int vocab_size);
    int pick;
    int start;
    start = sent;
    while (sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 68) begin
        send_vocab_word($urandom_range(vocab_size - 1));
      end else if (pick < 86) begin
        send_beat(CMD_QUERY, 8'($urandom),
                  ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(sb.stored_total)),
                  ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(5)));
      end else if (pick < 92) begin
        send_beat(CMD_PUSH, 8'($urandom), 6'($urandom), 6'($urandom));  // stray byte
      end else if (pick < 97) begin
        send_beat(CMD_END, 8'($urandom), 6'($urandom), 6'($urandom));   // often empty
      end else if (pick < 99) begin
        send_beat(CMD_QUERY, 8'($urandom), 6'($urandom), 6'($urandom));
      end else begin
        send_beat(CMD_CLEAR, 8'($urandom), 6'($urandom), 6'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    sent  = 0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, match/insert, empty word, overlong word, queries, clear
    send_beat(CMD_PUSH, 8'h00, 6'h3F, 6'h3F);
    send_beat(CMD_PUSH, 8'hFF, 6'h00, 6'h00);
    send_beat(CMD_END, 8'h00, 6'h00, 6'h00);      // new entry
    send_beat(CMD_PUSH, 8'h00, 6'h00, 6'h00);
    send_beat(CMD_PUSH, 8'hFF, 6'h00, 6'h00);
    send_beat(CMD_END, 8'hFF, 6'h3F, 6'h3F);      // repeat, sets duplicate flag
    send_beat(CMD_PUSH, 8'h00, 6'h00, 6'h00);
    send_beat(CMD_END, 8'h00, 6'h00, 6'h00);      // same prefix, shorter: new
    send_beat(CMD_END, 8'h00, 6'h00, 6'h00);      // empty word
    send_beat(CMD_QUERY, 8'h00, 6'd0, 6'd0);
    send_beat(CMD_QUERY, 8'h00, 6'd0, 6'd1);
    send_beat(CMD_QUERY, 8'h00, 6'd0, 6'd2);      // past the word's end
    send_beat(CMD_QUERY, 8'h00, 6'd63, 6'd63);    // unused entry
    for (int k = 0; k < MAX_WORD_LEN + 2; k++)    // overlong word, truncated
      send_beat(CMD_PUSH, 8'(k * 5 + 1), '0, '0);
    send_beat(CMD_END, 8'h00, 6'h00, 6'h00);
    send_beat(CMD_QUERY, 8'h00, 6'd2, 6'd48);     // last stored byte
    send_beat(CMD_QUERY, 8'h00, 6'd2, 6'd49);
    send_beat(CMD_PUSH, 8'h41, 6'h00, 6'h00);     // partial word survives a clear
    send_beat(CMD_CLEAR, 8'hFF, 6'h3F, 6'h3F);
    send_beat(CMD_END, 8'h00, 6'h00, 6'h00);
    send_beat(CMD_QUERY, 8'h00, 6'd0, 6'd0);

    // no idling, with one long receiver hold-off so the block backs up
    fill_vocab();
    ->hold_go;
    random_phase(ITEMS_PER_PHASE, 96);            // large vocabulary fills the table

    idle_pct  = 81;
    stall_pct = 0;
    send_beat(CMD_CLEAR, 8'h00, 6'h00, 6'h00);
    fill_vocab();
    random_phase(ITEMS_PER_PHASE, 12);

    idle_pct  = 0;
    stall_pct = 81;
    random_phase(ITEMS_PER_PHASE, 40);

    idle_pct  = 19;
    stall_pct = 19;
    fill_vocab();
    random_phase(ITEMS_PER_PHASE, 80);

    in_chan.valid <= 1'b0;
    stall_pct = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("PASS duplicate_word_counter_unit");
    end else begin
      $display("FAIL duplicate_word_counter_unit");
    end
    $finish;
  end
endmodule
